// ----- hw/rtl/ste_pkg.sv -----
// Shared constants, coefficient tables and helpers for the spheroidal taper evaluator.
// Depends on nothing; imported by ste_mulq_add, ste_div and spheroidal_taper_evaluator.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  // Field widths and default fraction bits
  localparam int IN_W          = 17;
  localparam int OUT_W         = 18;
  localparam int FRAC_BITS_DEF = 16;

  // Internal fixed point: Q.30 in 32-bit signed words
  localparam int QB  = 30;
  localparam int Q_W = QB + 2;

  typedef logic signed [Q_W-1:0] q30_t;

  localparam longint ONE_L = 64'sd1 <<< QB;

  localparam q30_t ONE_Q     = q30_t'(ONE_L);
  localparam q30_t EDGE_Q    = q30_t'(64'sd805306368);
  localparam q30_t EDGE_SQ_Q = q30_t'(64'sd603979776);

  // Numerator coefficients, inner segment
  localparam q30_t P00 = q30_t'((64'sd8203343 * ONE_L + 64'sd50000000) / 64'sd100000000);
  localparam q30_t P01 = q30_t'(-((64'sd3644705 * ONE_L + 64'sd5000000) / 64'sd10000000));
  localparam q30_t P02 = q30_t'((64'sd627866 * ONE_L + 64'sd500000) / 64'sd1000000);
  localparam q30_t P03 = q30_t'(-((64'sd5335581 * ONE_L + 64'sd5000000) / 64'sd10000000));
  localparam q30_t P04 = q30_t'((64'sd2312756 * ONE_L + 64'sd5000000) / 64'sd10000000);
  // Numerator coefficients, outer segment
  localparam q30_t P10 = q30_t'((64'sd4028559 * ONE_L + 64'sd500000000) / 64'sd1000000000);
  localparam q30_t P11 = q30_t'(-((64'sd3697768 * ONE_L + 64'sd50000000) / 64'sd100000000));
  localparam q30_t P12 = q30_t'((64'sd1021332 * ONE_L + 64'sd5000000) / 64'sd10000000);
  localparam q30_t P13 = q30_t'(-((64'sd1201436 * ONE_L + 64'sd5000000) / 64'sd10000000));
  localparam q30_t P14 = q30_t'((64'sd6412774 * ONE_L + 64'sd50000000) / 64'sd100000000);
  // Denominator coefficients
  localparam q30_t Q01 = q30_t'((64'sd8212018 * ONE_L + 64'sd5000000) / 64'sd10000000);
  localparam q30_t Q02 = q30_t'((64'sd2078043 * ONE_L + 64'sd5000000) / 64'sd10000000);
  localparam q30_t Q11 = q30_t'((64'sd9599102 * ONE_L + 64'sd5000000) / 64'sd10000000);
  localparam q30_t Q12 = q30_t'((64'sd2918724 * ONE_L + 64'sd5000000) / 64'sd10000000);

  localparam q30_t NUM_COEF [2][5] = '{'{P00, P01, P02, P03, P04},
                                       '{P10, P11, P12, P13, P14}};
  localparam q30_t DEN_COEF [2][3] = '{'{ONE_Q, Q01, Q02},
                                       '{ONE_Q, Q11, Q12}};

  // Output saturation bounds
  localparam longint OUT_MAX = 64'sd131071;
  localparam longint OUT_MIN = -64'sd131072;

  // Sideband through the Horner stages
  typedef struct packed {
    logic oor;
    logic seg;
    q30_t d;
    q30_t om;
  } hsb_t;

  // Sideband through the divider
  typedef struct packed {
    logic oor;
    logic zero;
    logic neg;
    q30_t om;
  } dsb_t;

  // Clamp to the signed output field
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > OUT_MAX) begin
      res = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      res = OUT_W'(OUT_MIN);
    end else begin
      res = OUT_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spheroidal_taper_evaluator.sv -----
// Top level of the spheroidal taper evaluator: square, Horner chains, divider, taper.
// Depends on ste_pkg, ste_mulq_add and ste_div.
//
// Usage:
//   Input channel in_valid/in_ready carries one |x| per beat (unsigned, FRAC_BITS
//   fraction bits). Output channel out_valid/out_ready carries the spheroid value,
//   the tapered value spheroid*(1 - x^2), both saturated to 18-bit signed, and an
//   out-of-range flag (x above 1.0, values forced to zero).
//   Throughput: one beat per cycle unless the receiver stalls. The pipeline depth
//   is set mostly by the divider, which resolves one quotient bit per stage
//   (FRAC_BITS + 2 stages); the rest is the square and its rounding, four Horner
//   steps of two stages each, divider set-up, sign, the taper multiply (two stages)
//   and the output register.
//   Reset (rst_n low, synchronous) empties the pipeline; no item is in flight after.
//   When the receiver stalls on a valid output, the whole pipeline holds, in_ready
//   drops, and nothing is lost or repeated; the last stage is the output register.
`timescale 1ns / 1ps
`default_nettype none

module spheroidal_taper_evaluator #(
  parameter int FRAC_BITS = ste_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ste_pkg::IN_W-1:0]          in_abs_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ste_pkg::OUT_W-1:0]  out_spheroid_value,
  output logic signed [ste_pkg::OUT_W-1:0]  out_tapered_value,
  output logic                              out_out_of_range
);
  import ste_pkg::*;

  localparam int QW  = FRAC_BITS + 2;       // quotient bits
  localparam int DW  = Q_W;                 // divisor magnitude
  localparam int NW  = Q_W + FRAC_BITS + 1; // dividend incl. rounding carry
  localparam int SW  = QW + 1;              // signed spheroid
  localparam int TW  = SW + 1;              // taper product
  localparam int XW  = QB + 1;              // x in Q.30, non-negative
  localparam int PXW = 2 * XW;
  localparam int LAT = QW + 15;

  // Stage indexes in the valid line
  localparam int V_H0   = 1;
  localparam int V_PREP = V_H0 + 9;
  localparam int V_SIGN = V_PREP + QW + 1;

  localparam logic [DW-1:0] POS_ONE = DW'(64'd1 << FRAC_BITS);

  logic en;
  logic vld_r [LAT];

  // Global advance: the output register frees or is taken
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  // Valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: x in Q.30, range check, segment, square
  logic [XW-1:0]  xi;
  logic [PXW-1:0] xsq_r;
  logic           oor1_r, seg1_r;

  assign xi = XW'({{(XW-IN_W){1'b0}}, in_abs_position} << (QB - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      xsq_r  <= PXW'(xi) * PXW'(xi);
      oor1_r <= {{(DW-IN_W){1'b0}}, in_abs_position} > POS_ONE;
      seg1_r <= xi >= XW'(EDGE_Q);
    end
  end

  // Stage 2: round x^2, offset from segment end, 1 - x^2
  logic [PXW-1:0] x2_full;
  q30_t           x2;
  hsb_t           hsb_nxt;
  hsb_t           sb_r [9];

  always_comb begin
    x2_full     = (xsq_r + (PXW'(1) << (QB - 1))) >> QB;
    x2          = q30_t'(x2_full);
    hsb_nxt.oor = oor1_r;
    hsb_nxt.seg = seg1_r;
    hsb_nxt.d   = x2 - (seg1_r ? ONE_Q : EDGE_SQ_Q);
    hsb_nxt.om  = ONE_Q - x2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= hsb_nxt;
      for (int i = 1; i < 9; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // Horner chains: four steps for numerator and denominator side by side
  q30_t top_y [4];
  q30_t bot_y [4];

  for (genvar k = 0; k < 4; k++) begin : g_horner
    q30_t top_b, top_c, bot_b, bot_c;

    assign top_c = NUM_COEF[sb_r[2*k].seg][3-k];

    if (k == 0) begin : g_first
      assign top_b = NUM_COEF[sb_r[0].seg][4];
      assign bot_b = '0;
      assign bot_c = '0;
    end else begin : g_next
      assign top_b = top_y[k-1];
      assign bot_b = bot_y[k-1];
      assign bot_c = DEN_COEF[sb_r[2*k].seg][3-k];
    end

    ste_mulq_add #(.AW(Q_W), .BW(Q_W), .CW(Q_W), .RW(Q_W)) u_top (
      .clk (clk), .en (en), .a (sb_r[2*k].d), .b (top_b), .c (top_c), .y (top_y[k])
    );

    ste_mulq_add #(.AW(Q_W), .BW(Q_W), .CW(Q_W), .RW(Q_W)) u_bot (
      .clk (clk), .en (en), .a (sb_r[2*k].d), .b (bot_b), .c (bot_c), .y (bot_y[k])
    );
  end

  // Divider set-up: magnitudes, dividend with half-divisor rounding
  logic [DW-1:0] tmag, bmag;
  logic [NW-1:0] n_r;
  logic [DW-1:0] bm_r;
  dsb_t          dsb_nxt;
  dsb_t          dsb_r [QW+1];

  always_comb begin
    tmag         = top_y[3][Q_W-1] ? DW'(-top_y[3]) : DW'(top_y[3]);
    bmag         = bot_y[3][Q_W-1] ? DW'(-bot_y[3]) : DW'(bot_y[3]);
    dsb_nxt.oor  = sb_r[8].oor;
    dsb_nxt.zero = bot_y[3] == '0;
    dsb_nxt.neg  = top_y[3][Q_W-1] ^ bot_y[3][Q_W-1];
    dsb_nxt.om   = sb_r[8].om;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= (NW'(tmag) << FRAC_BITS) + NW'(bmag >> 1);
      bm_r     <= bmag;
      dsb_r[0] <= dsb_nxt;
      for (int i = 1; i <= QW; i++) dsb_r[i] <= dsb_r[i-1];
    end
  end

  logic [QW-1:0] quo;

  ste_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk (clk), .en (en), .num (n_r), .den (bm_r), .quo (quo)
  );

  // Sign of the quotient
  logic signed [SW-1:0] sph_nxt;
  logic signed [SW-1:0] sph_r;
  logic                 kill_s_r, oor_s_r;
  q30_t                 om_s_r;

  assign sph_nxt = dsb_r[QW].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (en) begin
      sph_r    <= sph_nxt;
      kill_s_r <= dsb_r[QW].oor || dsb_r[QW].zero;
      oor_s_r  <= dsb_r[QW].oor;
      om_s_r   <= dsb_r[QW].om;
    end
  end

  // Taper multiply, with spheroid and flags carried alongside
  logic signed [TW-1:0] tap;
  logic signed [SW-1:0] sph_t_r [2];
  logic                 kill_t_r [2];
  logic                 oor_t_r [2];

  ste_mulq_add #(.AW(SW), .BW(Q_W), .CW(TW), .RW(TW)) u_taper (
    .clk (clk), .en (en), .a (sph_r), .b (om_s_r), .c ('0), .y (tap)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sph_t_r[0]  <= sph_r;
      kill_t_r[0] <= kill_s_r;
      oor_t_r[0]  <= oor_s_r;
      sph_t_r[1]  <= sph_t_r[0];
      kill_t_r[1] <= kill_t_r[0];
      oor_t_r[1]  <= oor_t_r[0];
    end
  end

  // Output register: saturate, force zero on range or zero denominator
  logic signed [OUT_W-1:0] sph_out_r, tap_out_r;
  logic                    oor_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sph_out_r <= kill_t_r[1] ? '0 : sat_out(64'(sph_t_r[1]));
      tap_out_r <= kill_t_r[1] ? '0 : sat_out(64'(tap));
      oor_out_r <= oor_t_r[1];
    end
  end

  assign out_valid          = vld_r[LAT-1];
  assign out_spheroid_value = sph_out_r;
  assign out_tapered_value  = tap_out_r;
  assign out_out_of_range   = oor_out_r;

  // Checks
  a_d_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_H0] && !sb_r[0].oor |-> sb_r[0].d <= 0)
    else $error("segment offset positive inside the domain");

  a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_PREP] && !dsb_r[0].oor |-> (n_r >> QW) < NW'(bm_r))
    else $error("quotient would overflow the divider");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_SIGN] && oor_s_r |-> kill_s_r)
    else $error("out-of-range item not forced to zero");

  a_out_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_spheroid_value == '0 && out_tapered_value == '0)
    else $error("out-of-range result carries a value");

endmodule

`default_nettype wire

// ----- hw/rtl/ste_mulq_add.sv -----
// Two-stage multiply, round to Q.30 (half away from zero) and add: y = c + round(a*b / 2^30).
// Depends on ste_pkg for the fraction width.
`timescale 1ns / 1ps
`default_nettype none

module ste_mulq_add #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int CW = 32,
  parameter int RW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  input  logic signed [CW-1:0] c,
  output logic signed [RW-1:0] y
);
  import ste_pkg::*;

  localparam int PW = AW + BW;

  logic [AW-1:0]          am;
  logic [BW-1:0]          bm;
  logic [PW-1:0]          p_nxt, p_r;
  logic                   neg_r;
  logic signed [CW-1:0]   c_r;
  logic [PW-1:0]          rnd;
  logic signed [RW-1:0]   r_s;
  logic signed [RW-1:0]   y_nxt, y_r;

  // Stage one: magnitude product
  always_comb begin
    am    = a[AW-1] ? AW'(-a) : AW'(a);
    bm    = b[BW-1] ? BW'(-b) : BW'(b);
    p_nxt = PW'(am) * PW'(bm);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      neg_r <= a[AW-1] ^ b[BW-1];
      c_r   <= c;
    end
  end

  // Stage two: round, restore sign, accumulate
  always_comb begin
    rnd   = (p_r + (PW'(1) << (QB - 1))) >> QB;
    r_s   = $signed(RW'(rnd));
    y_nxt = RW'(c_r) + (neg_r ? -r_s : r_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ste_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Imports ste_pkg; instanced by the top level.
`timescale 1ns / 1ps
`default_nettype none

module ste_div #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int QW = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  import ste_pkg::*;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [DW-1:0] rem_r;
    logic [NW-1:0] num_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = g_stage[i-1].rem_r;
      assign num_in = g_stage[i-1].num_r;
      assign den_in = g_stage[i-1].den_r;
      assign quo_in = g_stage[i-1].quo_r;
    end

    // Shift in the next dividend bit and try a subtract
    always_comb begin
      trial   = {rem_in, num_in[QW-1-i]};
      ge      = trial >= {1'b0, den_in};
      rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        num_r <= num_in;
        den_r <= den_in;
        quo_r <= QW'({quo_in, ge});
      end
    end
  end

  assign quo = g_stage[QW-1].quo_r;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for spheroidal_taper_evaluator: directed and random positions.
// Depends on ste_pkg and the evaluator RTL; predicts each result in fixed point.
`timescale 1ns / 1ps

module tb_top;
  import ste_pkg::*;

  localparam int FB = 16;
  localparam int LAT = FB + 17;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [OUT_W-1:0] sph;
    logic signed [OUT_W-1:0] tap;
    logic                    oor;
  } taper_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] in_abs_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_spheroid_value;
  logic signed [OUT_W-1:0] out_tapered_value;
  logic out_out_of_range;

  taper_res_t pending_taper[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;
  bit sink_busy = 1'b1;

  always #10 clk = ~clk;

  spheroidal_taper_evaluator #(.FRAC_BITS(FB)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_abs_position,
    .out_valid, .out_ready, .out_spheroid_value, .out_tapered_value, .out_out_of_range
  );

  // Q.30 coefficient from decimal fraction n/d, rounded to nearest
  function automatic longint coef_q(longint n, longint d);
    return ((n << 30) + d / 2) / d;
  endfunction

  // Q.30 product, rounded half away from zero
  function automatic longint mul_q30(longint a, longint b);
    logic [63:0] ma, mb, p, r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = ma * mb;
    r = (p + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp18(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return OUT_W'(-131072);
    return v[OUT_W-1:0];
  endfunction

  function automatic taper_res_t predict_taper(logic [IN_W-1:0] pos);
    taper_res_t r;
    longint xi, x2, d, top, bot, sph, pc[5], qc[3];
    logic [63:0] q, bm, tm;
    bit seg;
    r = '0;
    if (pos > (17'd1 << FB)) begin
      r.oor = 1'b1;
      return r;
    end
    xi = longint'(pos) << (30 - FB);
    x2 = (xi * xi + (64'sd1 << 29)) >>> 30;
    seg = xi >= 64'sd805306368;
    if (!seg) begin
      pc = '{coef_q(8203343, 100000000), -coef_q(3644705, 10000000),
             coef_q(627866, 1000000), -coef_q(5335581, 10000000),
             coef_q(2312756, 10000000)};
      qc = '{64'sd1 << 30, coef_q(8212018, 10000000), coef_q(2078043, 10000000)};
      d = x2 - 64'sd603979776;
    end else begin
      pc = '{coef_q(4028559, 1000000000), -coef_q(3697768, 100000000),
             coef_q(1021332, 10000000), -coef_q(1201436, 10000000),
             coef_q(6412774, 100000000)};
      qc = '{64'sd1 << 30, coef_q(9599102, 10000000), coef_q(2918724, 10000000)};
      d = x2 - (64'sd1 << 30);
    end
    top = pc[4];
    for (int i = 3; i >= 0; i--) top = pc[i] + mul_q30(d, top);
    bot = qc[2];
    for (int i = 1; i >= 0; i--) bot = qc[i] + mul_q30(d, bot);
    if (bot == 0) return r;
    bm = bot < 0 ? -bot : bot;
    tm = top < 0 ? -top : top;
    q = ((tm << FB) + bm / 2) / bm;
    sph = ((top < 0) != (bot < 0)) ? -longint'(q) : longint'(q);
    r.sph = clamp18(sph);
    r.tap = clamp18(mul_q30(sph, (64'sd1 << 30) - x2));
    return r;
  endfunction

  // Short gaps mostly, an occasional long one
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat and wait until it is taken; valid stays up between beats unless a gap is drawn
  task automatic send_position(logic [IN_W-1:0] pos, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_abs_position <= pos;
    pending_taper.push_back(predict_taper(pos));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_directed();
    logic [IN_W-1:0] pts[$];
    pts = {17'd0, 17'd1, 17'd32768, 17'd49151, 17'd49152, 17'd49153, 17'd60000,
           17'd65535, 17'd65536, 17'd65537, 17'd98304, 17'd131070, 17'd131071,
           17'h0AAAA, 17'h15555};
    sink_busy = 1'b0;
    foreach (pts[i]) send_position(pts[i], 1'b0);
    sink_busy = 1'b1;
  endtask

  task automatic test_random();
    int k;
    for (int n = 0; n < 2000; n++) begin
      k = $urandom_range(0, 9);
      if (k < 7) send_position(IN_W'($urandom_range(0, 65536)), 1'b1);
      else if (k < 8) send_position(IN_W'($urandom_range(49100, 49200)), 1'b1);
      else send_position(IN_W'($urandom_range(0, 131071)), 1'b1);
    end
  endtask

  // Sink stalls for a long stretch while the source streams back to back
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int n = 0; n < 3 * LAT; n++)
      send_position(IN_W'($urandom_range(0, 131071)), 1'b0);
    hold_sink = 1'b0;
  endtask

  // Long hold-off counted in its own process
  always @(posedge clk) begin : sink_drive
    static int hold_cnt = 0;
    if (hold_sink && hold_cnt < 200) begin
      hold_cnt++;
      out_ready <= 1'b0;
    end else begin
      if (!hold_sink) hold_cnt = 0;
      out_ready <= !sink_busy || ($urandom_range(0, 99) < 70) ||
                   (hold_cnt >= 200 && hold_sink);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    taper_res_t exp_r;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_taper.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat");
      end else begin
        exp_r = pending_taper.pop_front();
        if (exp_r.sph !== out_spheroid_value || exp_r.tap !== out_tapered_value ||
            exp_r.oor !== out_out_of_range) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp sph=%0d tap=%0d oor=%0b got sph=%0d tap=%0d oor=%0b",
                     exp_r.sph, exp_r.tap, exp_r.oor, out_spheroid_value,
                     out_tapered_value, out_out_of_range);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_taper.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && pending_taper.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
